/* rtl/rpmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmt_pkg
// Shared widths, codes, types and lookup tables for the radio panel menu tuner.
// ----------------------------------------------------------------------------
package rpmt_pkg;

  // Field widths
  localparam int PIN_W     = 5;
  localparam int MENU_W    = 3;
  localparam int OPT_W     = 3;
  localparam int FREQ_W    = 25;
  localparam int STEP_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int EV_W      = 4;

  // Menu layout
  localparam int NUM_MENUS = 6;
  localparam logic [MENU_W-1:0] MENU_TUNE  = 3'd0;
  localparam logic [MENU_W-1:0] MENU_FIRST = 3'd1;
  localparam logic [MENU_W-1:0] MENU_LAST  = 3'd5;
  localparam logic [OPT_W-1:0]  DIGIT_LAST = 3'd6;
  localparam logic [OPT_W-1:0]  OPT_ZERO   = 3'd0;

  // Reset values
  localparam logic [OPT_W-1:0]  OPTION_RESET = 3'd4;
  localparam logic [FREQ_W-1:0] FREQ_RESET   = 25'd7050000;
  localparam logic [FREQ_W-1:0] MAX_RESET    = 25'd30000000;
  localparam logic [FREQ_W-1:0] MIN_RESET    = 25'd100;

  // Pin numbers
  localparam logic [PIN_W-1:0] PIN_ENC_A  = 5'd2;
  localparam logic [PIN_W-1:0] PIN_ENTER  = 5'd6;
  localparam logic [PIN_W-1:0] PIN_ESCAPE = 5'd7;
  localparam logic [PIN_W-1:0] PIN_LEFT   = 5'd8;
  localparam logic [PIN_W-1:0] PIN_RIGHT  = 5'd9;
  localparam logic [PIN_W-1:0] PIN_PTT    = 5'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B_HIGH_UP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTH_EDGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ   = 2'd3;

  // Decoded panel events
  typedef logic [EV_W-1:0] ev_code_t;
  localparam ev_code_t EV_NONE    = 4'd0;
  localparam ev_code_t EV_INC     = 4'd1;
  localparam ev_code_t EV_DEC     = 4'd2;
  localparam ev_code_t EV_ENTER   = 4'd3;
  localparam ev_code_t EV_ESC     = 4'd4;
  localparam ev_code_t EV_LEFT    = 4'd5;
  localparam ev_code_t EV_RIGHT   = 4'd6;
  localparam ev_code_t EV_PTT_ON  = 4'd7;
  localparam ev_code_t EV_PTT_OFF = 4'd8;

  // Configuration register set
  typedef struct packed {
    logic              b_high_is_up;
    logic              both_edges;
    logic [FREQ_W-1:0] max_frequency;
    logic [FREQ_W-1:0] min_frequency;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [MENU_W-1:0] menu_state;
    logic [OPT_W-1:0]  selected_option;
    logic [FREQ_W-1:0] frequency;
    logic              talk_active;
    logic              update_flag;
    logic [1:0]        mode_setting;
    logic [1:0]        agc_setting;
    logic [2:0]        preamp_setting;
    logic [1:0]        vox_setting;
    logic [2:0]        band_setting;
  } result_t;

  // Tuning increment of each digit; the last digit and anything past it use 50 Hz
  function automatic logic [STEP_W-1:0] digit_step(input logic [OPT_W-1:0] digit);
    logic [STEP_W-1:0] step;
    case (digit)
      3'd0:    step = 24'd10000000;
      3'd1:    step = 24'd1000000;
      3'd2:    step = 24'd100000;
      3'd3:    step = 24'd10000;
      3'd4:    step = 24'd1000;
      3'd5:    step = 24'd100;
      default: step = 24'd50;
    endcase
    return step;
  endfunction

  // Highest option of each menu (size minus one)
  function automatic logic [OPT_W-1:0] menu_top(input logic [MENU_W-1:0] menu);
    logic [OPT_W-1:0] top;
    case (menu)
      3'd0:    top = 3'd6;
      3'd1:    top = 3'd3;
      3'd2:    top = 3'd2;
      3'd3:    top = 3'd4;
      3'd4:    top = 3'd3;
      3'd5:    top = 3'd4;
      default: top = 3'd0;
    endcase
    return top;
  endfunction

  // Saved option of each menu after reset
  function automatic logic [OPT_W-1:0] saved_reset(input logic [MENU_W-1:0] menu);
    logic [OPT_W-1:0] val;
    case (menu)
      3'd0:    val = 3'd4;
      3'd1:    val = 3'd1;
      3'd2:    val = 3'd2;
      3'd3:    val = 3'd3;
      3'd4:    val = 3'd0;
      3'd5:    val = 3'd2;
      default: val = 3'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/rpmt_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmt channel interfaces
// Valid/ready channels for pin events, panel results and configuration writes.
// ----------------------------------------------------------------------------

// Pin edge events
interface rpmt_pin_if;
  logic                         valid;
  logic                         ready;
  logic [rpmt_pkg::PIN_W-1:0]   pin_number;
  logic                         edge_fall;
  logic                         edge_rise;
  logic                         encoder_b_level;

  modport source (output valid, pin_number, edge_fall, edge_rise, encoder_b_level,
                  input ready);
  modport sink   (input valid, pin_number, edge_fall, edge_rise, encoder_b_level,
                  output ready);
endinterface

// Panel state results
interface rpmt_panel_if;
  logic                          valid;
  logic                          ready;
  logic [rpmt_pkg::MENU_W-1:0]   menu_state;
  logic [rpmt_pkg::OPT_W-1:0]    selected_option;
  logic [rpmt_pkg::FREQ_W-1:0]   frequency;
  logic                          talk_active;
  logic                          update_flag;
  logic [1:0]                    mode_setting;
  logic [1:0]                    agc_setting;
  logic [2:0]                    preamp_setting;
  logic [1:0]                    vox_setting;
  logic [2:0]                    band_setting;

  modport source (output valid, menu_state, selected_option, frequency, talk_active,
                  update_flag, mode_setting, agc_setting, preamp_setting,
                  vox_setting, band_setting, input ready);
  modport sink   (input valid, menu_state, selected_option, frequency, talk_active,
                  update_flag, mode_setting, agc_setting, preamp_setting,
                  vox_setting, band_setting, output ready);
endinterface

// Configuration writes
interface rpmt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpmt_pkg::CFG_IDX_W-1:0]   index;
  logic [rpmt_pkg::FREQ_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rpmt_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmt_decode
// Turns one pin edge event into a panel event code.
// ----------------------------------------------------------------------------
module rpmt_decode (
  input  logic [rpmt_pkg::PIN_W-1:0] pin_number,
  input  logic                       edge_fall,
  input  logic                       edge_rise,
  input  logic                       encoder_b_level,
  input  rpmt_pkg::cfg_t             cfg_q,
  output rpmt_pkg::ev_code_t         ev
);

  logic up;

  // Encoder direction sense
  assign up = cfg_q.b_high_is_up ? encoder_b_level : !encoder_b_level;

  // Falling edge wins on the encoder, rising edge wins on PTT
  always_comb begin
    ev = rpmt_pkg::EV_NONE;
    case (pin_number)
      rpmt_pkg::PIN_ENC_A: begin
        if (edge_fall) begin
          ev = up ? rpmt_pkg::EV_INC : rpmt_pkg::EV_DEC;
        end else if (edge_rise && cfg_q.both_edges) begin
          ev = up ? rpmt_pkg::EV_DEC : rpmt_pkg::EV_INC;
        end
      end
      rpmt_pkg::PIN_ENTER:  if (edge_fall) ev = rpmt_pkg::EV_ENTER;
      rpmt_pkg::PIN_ESCAPE: if (edge_fall) ev = rpmt_pkg::EV_ESC;
      rpmt_pkg::PIN_LEFT:   if (edge_fall) ev = rpmt_pkg::EV_LEFT;
      rpmt_pkg::PIN_RIGHT:  if (edge_fall) ev = rpmt_pkg::EV_RIGHT;
      rpmt_pkg::PIN_PTT: begin
        if (edge_rise) begin
          ev = rpmt_pkg::EV_PTT_OFF;
        end else if (edge_fall) begin
          ev = rpmt_pkg::EV_PTT_ON;
        end
      end
      default: ev = rpmt_pkg::EV_NONE;
    endcase
  end

endmodule

/* rtl/rpmt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmt_core
// Panel state registers and the next-state logic for one decoded event.
// ----------------------------------------------------------------------------
module rpmt_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  rpmt_pkg::ev_code_t  ev,
  input  rpmt_pkg::cfg_t      cfg_q,
  output rpmt_pkg::result_t   res_next
);

  // State
  logic [rpmt_pkg::MENU_W-1:0] menu, menu_next;
  logic [rpmt_pkg::OPT_W-1:0]  option, option_next;
  logic [rpmt_pkg::FREQ_W-1:0] tuned_hz, tuned_hz_next;
  logic [rpmt_pkg::OPT_W-1:0]  saved [rpmt_pkg::NUM_MENUS];
  logic [rpmt_pkg::OPT_W-1:0]  saved_next [rpmt_pkg::NUM_MENUS];
  logic                        talk_on, talk_on_next;
  logic                        committed, committed_next;

  // Helpers
  logic [rpmt_pkg::STEP_W-1:0] step;
  logic [rpmt_pkg::FREQ_W:0]   inc_sum;
  logic [rpmt_pkg::FREQ_W:0]   dec_floor;
  logic                        inc_ok, dec_ok;
  logic [rpmt_pkg::OPT_W-1:0]  top;
  logic                        sub_ok;
  logic [rpmt_pkg::MENU_W-1:0] right_menu, left_clip, left_menu;

  // Tuning step and bound checks
  assign step      = rpmt_pkg::digit_step(option);
  assign inc_sum   = {1'b0, tuned_hz} + {2'b00, step};
  assign dec_floor = {2'b00, step} + {1'b0, cfg_q.min_frequency};
  assign inc_ok    = inc_sum < {1'b0, cfg_q.max_frequency};
  assign dec_ok    = {1'b0, tuned_hz} > dec_floor;

  // Submenu clamp and rotation
  assign sub_ok     = menu <= rpmt_pkg::MENU_LAST;
  assign top        = sub_ok ? rpmt_pkg::menu_top(menu) : rpmt_pkg::OPT_ZERO;
  assign right_menu = (menu < rpmt_pkg::MENU_LAST) ? 3'(menu + 3'd1) : rpmt_pkg::MENU_FIRST;
  assign left_clip  = sub_ok ? menu : rpmt_pkg::MENU_LAST;
  assign left_menu  = (left_clip > rpmt_pkg::MENU_FIRST) ? 3'(left_clip - 3'd1)
                                                         : rpmt_pkg::MENU_LAST;

  // Next state
  always_comb begin
    menu_next      = menu;
    option_next    = option;
    tuned_hz_next  = tuned_hz;
    saved_next     = saved;
    talk_on_next   = talk_on;
    committed_next = committed;
    if (menu == rpmt_pkg::MENU_TUNE) begin
      case (ev)
        rpmt_pkg::EV_PTT_ON:  talk_on_next = 1'b1;
        rpmt_pkg::EV_PTT_OFF: talk_on_next = 1'b0;
        rpmt_pkg::EV_ESC: begin
          saved_next[0] = option;
          menu_next     = rpmt_pkg::MENU_FIRST;
          option_next   = saved[1];
        end
        rpmt_pkg::EV_INC: if (inc_ok) tuned_hz_next = inc_sum[rpmt_pkg::FREQ_W-1:0];
        rpmt_pkg::EV_DEC: if (dec_ok) tuned_hz_next = tuned_hz - {1'b0, step};
        rpmt_pkg::EV_RIGHT: begin
          option_next = (option < rpmt_pkg::DIGIT_LAST) ? 3'(option + 3'd1)
                                                        : rpmt_pkg::DIGIT_LAST;
        end
        rpmt_pkg::EV_LEFT: begin
          option_next = (option > rpmt_pkg::OPT_ZERO) ? 3'(option - 3'd1)
                                                      : rpmt_pkg::OPT_ZERO;
        end
        default: ;
      endcase
    end else begin
      case (ev)
        rpmt_pkg::EV_INC: begin
          if (sub_ok) option_next = (option < top) ? 3'(option + 3'd1) : top;
        end
        rpmt_pkg::EV_DEC: begin
          if (sub_ok) begin
            option_next = (option > rpmt_pkg::OPT_ZERO) ? 3'(option - 3'd1)
                                                        : rpmt_pkg::OPT_ZERO;
          end
        end
        rpmt_pkg::EV_ENTER: begin
          if (sub_ok) begin
            saved_next[menu] = option;
            committed_next   = 1'b1;
          end
        end
        rpmt_pkg::EV_ESC: begin
          menu_next   = rpmt_pkg::MENU_TUNE;
          option_next = saved[0];
        end
        rpmt_pkg::EV_RIGHT: begin
          menu_next   = right_menu;
          option_next = saved[right_menu];
        end
        rpmt_pkg::EV_LEFT: begin
          menu_next   = left_menu;
          option_next = saved[left_menu];
        end
        default: ;
      endcase
    end
  end

  // State registers, committed on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      menu      <= rpmt_pkg::MENU_TUNE;
      option    <= rpmt_pkg::OPTION_RESET;
      tuned_hz  <= rpmt_pkg::FREQ_RESET;
      talk_on   <= 1'b0;
      committed <= 1'b0;
      for (int i = 0; i < rpmt_pkg::NUM_MENUS; i++) begin
        saved[i] <= rpmt_pkg::saved_reset(3'(i));
      end
    end else if (step_en) begin
      menu      <= menu_next;
      option    <= option_next;
      tuned_hz  <= tuned_hz_next;
      talk_on   <= talk_on_next;
      committed <= committed_next;
      saved     <= saved_next;
    end
  end

  // Result view of the next state
  assign res_next.menu_state      = menu_next;
  assign res_next.selected_option = option_next;
  assign res_next.frequency       = tuned_hz_next;
  assign res_next.talk_active     = talk_on_next;
  assign res_next.update_flag     = committed_next;
  assign res_next.mode_setting    = saved_next[1][1:0];
  assign res_next.agc_setting     = saved_next[2][1:0];
  assign res_next.preamp_setting  = saved_next[3];
  assign res_next.vox_setting     = saved_next[4][1:0];
  assign res_next.band_setting    = saved_next[5];

  // Checks
  a_menu_range: assert property (@(posedge clk) disable iff (rst)
    menu <= rpmt_pkg::MENU_LAST)
    else $error("menu out of range");

  a_option_range: assert property (@(posedge clk) disable iff (rst)
    option <= rpmt_pkg::DIGIT_LAST)
    else $error("option out of range");

  a_mark_sticky: assert property (@(posedge clk) disable iff (rst)
    committed |=> committed)
    else $error("update flag cleared without reset");

  a_ptt_tune_only: assert property (@(posedge clk) disable iff (rst)
    (step_en && menu != rpmt_pkg::MENU_TUNE) |=> $stable(talk_on))
    else $error("PTT changed outside tune state");

  a_freq_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(tuned_hz))
    else $error("frequency changed with no item");

endmodule

/* rtl/radio_panel_menu_tuner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_panel_menu_tuner
// Front-panel menu and tuning controller: pin events in, panel state out.
// ----------------------------------------------------------------------------
// Path: each pin event is held in the input register, then in the result register,
//   which offers it on the panel channel; a waiting result can stall it between them.
// Throughput: one pin event per cycle; a waiting result stalls the core, the
//   input register takes one more item and then holds the input off.
// Reset (rst, synchronous): tune state, kHz digit, 7.050 MHz, default options,
//   PTT off, update flag clear, configuration back to its defaults.
module radio_panel_menu_tuner (
  input  logic         clk,
  input  logic         rst,
  rpmt_pin_if.sink     pins,
  rpmt_panel_if.source panel,
  rpmt_cfg_if.sink     cfg
);

  rpmt_pkg::cfg_t     cfg_q;
  rpmt_pkg::ev_code_t ev;
  rpmt_pkg::result_t  res_next;
  rpmt_pkg::result_t  res;

  // Input register
  logic                       in_valid;
  logic [rpmt_pkg::PIN_W-1:0] in_pin;
  logic                       in_fall;
  logic                       in_rise;
  logic                       in_b;

  logic res_valid;
  logic advance;

  // Configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.b_high_is_up  <= 1'b1;
      cfg_q.both_edges    <= 1'b0;
      cfg_q.max_frequency <= rpmt_pkg::MAX_RESET;
      cfg_q.min_frequency <= rpmt_pkg::MIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rpmt_pkg::CFG_B_HIGH_UP:  cfg_q.b_high_is_up  <= cfg.data[0];
        rpmt_pkg::CFG_BOTH_EDGES: cfg_q.both_edges    <= cfg.data[0];
        rpmt_pkg::CFG_MAX_FREQ:   cfg_q.max_frequency <= cfg.data;
        rpmt_pkg::CFG_MIN_FREQ:   cfg_q.min_frequency <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake: the held item moves on when the result slot is free or draining
  assign advance    = in_valid && (!res_valid || panel.ready);
  assign pins.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pins.ready) begin
      in_valid <= pins.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pins.valid && pins.ready) begin
      in_pin  <= pins.pin_number;
      in_fall <= pins.edge_fall;
      in_rise <= pins.edge_rise;
      in_b    <= pins.encoder_b_level;
    end
  end

  rpmt_decode u_decode (
    .pin_number      (in_pin),
    .edge_fall       (in_fall),
    .edge_rise       (in_rise),
    .encoder_b_level (in_b),
    .cfg_q           (cfg_q),
    .ev              (ev)
  );

  rpmt_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .ev       (ev),
    .cfg_q    (cfg_q),
    .res_next (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (panel.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign panel.valid           = res_valid;
  assign panel.menu_state      = res.menu_state;
  assign panel.selected_option = res.selected_option;
  assign panel.frequency       = res.frequency;
  assign panel.talk_active     = res.talk_active;
  assign panel.update_flag     = res.update_flag;
  assign panel.mode_setting    = res.mode_setting;
  assign panel.agc_setting     = res.agc_setting;
  assign panel.preamp_setting  = res.preamp_setting;
  assign panel.vox_setting     = res.vox_setting;
  assign panel.band_setting    = res.band_setting;

  // Checks
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !panel.ready) |=> res_valid)
    else $error("pending result lost");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed item produced no result");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && res_valid && !panel.ready) |-> !pins.ready)
    else $error("input taken while both stages are full");

endmodule

/* test/radio_panel_menu_tuner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_panel_menu_tuner_tb
// Drives pin edge events into the panel controller and checks every panel
// state transfer against a cycle-free model of the menu and tuning logic.
// A short scripted sequence runs first, then random event streams under
// several tuning bounds and encoder senses, with idle gaps on both channels.
// ----------------------------------------------------------------------------
module radio_panel_menu_tuner_tb;
  import rpmt_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam logic [FREQ_W-1:0] FREQ_TOP = '1;

  // Pins that decode to nothing, lowest and highest
  localparam logic [PIN_W-1:0] NO_PIN_LO = 5'd0;
  localparam logic [PIN_W-1:0] NO_PIN_HI = 5'd31;

  localparam int unsigned TUNE_STEP_HZ [7] =
    '{10000000, 1000000, 100000, 10000, 1000, 100, 50};
  localparam int unsigned MENU_OPTIONS [NUM_MENUS] = '{7, 4, 3, 5, 4, 5};
  localparam logic [OPT_W-1:0] SAVED_DEFAULT [NUM_MENUS] =
    '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd2};

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             fall;
    logic             rise;
    logic             b_lvl;
    logic             typed;
    result_t          want;
  } panel_row_t;

  localparam result_t NOT_TYPED = '0;

  // Scripted opening; typed rows carry the panel state read straight off the spec
  localparam int SCRIPT_LEN = 25;
  localparam panel_row_t SCRIPT [SCRIPT_LEN] = '{
    '{NO_PIN_LO, 1'b0, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{NO_PIN_HI, 1'b1, 1'b1, 1'b1, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b1, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7051000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    // rising edge alone does nothing while single-edge stepping
    '{PIN_ENC_A, 1'b0, 1'b1, 1'b1, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7051000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    // both edges on the encoder: falling wins
    '{PIN_ENC_A, 1'b1, 1'b1, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_PTT, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b1, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    // both edges on PTT: rising wins
    '{PIN_PTT, 1'b1, 1'b1, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    // enter is ignored in tune state
    '{PIN_ENTER, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd4, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_RIGHT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_RIGHT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_RIGHT, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd6, 25'd7050000, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{PIN_LEFT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_ESCAPE, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_FIRST, 3'd1, 25'd7050050, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    // PTT is ignored outside tune state
    '{PIN_PTT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b1, 1'b1,
      result_t'{MENU_FIRST, 3'd3, 25'd7050050, 1'b0, 1'b0, 2'd1, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_ENTER, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_FIRST, 3'd3, 25'd7050050, 1'b0, 1'b1, 2'd3, 2'd2, 3'd3, 2'd0, 3'd2}},
    '{PIN_RIGHT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_LEFT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_LEFT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_RIGHT, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_ENC_A, 1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{PIN_ESCAPE, 1'b1, 1'b0, 1'b0, 1'b1,
      result_t'{MENU_TUNE, 3'd5, 25'd7050050, 1'b0, 1'b1, 2'd3, 2'd2, 3'd3, 2'd0, 3'd2}}
  };

  logic clk = 1'b0;
  logic rst;

  rpmt_pin_if   pin_ch ();
  rpmt_panel_if panel_ch ();
  rpmt_cfg_if   cfg_ch ();

  radio_panel_menu_tuner DUT (
    .clk   (clk),
    .rst   (rst),
    .pins  (pin_ch),
    .panel (panel_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Panel model state and its copy of the registers
  logic              enc_b_up;
  logic              enc_both;
  int unsigned       max_hz;
  int unsigned       min_hz;
  logic [MENU_W-1:0] menu_now;
  logic [OPT_W-1:0]  opt_now;
  int unsigned       freq_now;
  logic [OPT_W-1:0]  saved_opt [NUM_MENUS];
  logic              talk_now;
  logic              committed;

  result_t panel_due [$];
  int      mismatches = 0;

  // Typed expectation travelling with the offered event
  logic    row_typed;
  result_t row_want;

  logic        tx_calm = 1'b0;
  logic        rx_calm;
  int unsigned hold_asked;

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic ev_code_t decode_pin_event(logic [PIN_W-1:0] pin, logic fall,
                                                logic rise, logic b_lvl);
    logic up;
    up = enc_b_up ? b_lvl : !b_lvl;
    case (pin)
      PIN_ENC_A: begin
        if (fall) return up ? EV_INC : EV_DEC;
        if (rise && enc_both) return up ? EV_DEC : EV_INC;
      end
      PIN_ENTER:  if (fall) return EV_ENTER;
      PIN_ESCAPE: if (fall) return EV_ESC;
      PIN_LEFT:   if (fall) return EV_LEFT;
      PIN_RIGHT:  if (fall) return EV_RIGHT;
      PIN_PTT: begin
        if (rise) return EV_PTT_OFF;
        if (fall) return EV_PTT_ON;
      end
      default: ;
    endcase
    return EV_NONE;
  endfunction

  // Apply one event to the model and return the panel state after it
  function automatic result_t advance_panel(logic [PIN_W-1:0] pin, logic fall,
                                            logic rise, logic b_lvl);
    ev_code_t         ev;
    int unsigned      step;
    logic             known;
    logic [OPT_W-1:0] top;
    result_t          r;
    ev = decode_pin_event(pin, fall, rise, b_lvl);
    if (ev != EV_NONE && menu_now == MENU_TUNE) begin
      step = TUNE_STEP_HZ[(opt_now <= DIGIT_LAST) ? opt_now : DIGIT_LAST];
      case (ev)
        EV_PTT_ON:  talk_now = 1'b1;
        EV_PTT_OFF: talk_now = 1'b0;
        EV_ESC: begin
          saved_opt[0] = opt_now;
          menu_now = MENU_FIRST;
          opt_now = saved_opt[1];
        end
        // steps that would leave the tuning window are refused
        EV_INC: if (freq_now + step < max_hz) freq_now = freq_now + step;
        EV_DEC: if (freq_now > step + min_hz) freq_now = freq_now - step;
        EV_RIGHT: opt_now = (opt_now < DIGIT_LAST) ? opt_now + 3'd1 : DIGIT_LAST;
        EV_LEFT:  opt_now = (opt_now > OPT_ZERO) ? opt_now - 3'd1 : OPT_ZERO;
        default: ;
      endcase
    end else if (ev != EV_NONE) begin
      known = menu_now < NUM_MENUS;
      top = known ? OPT_W'(MENU_OPTIONS[menu_now] - 1) : OPT_ZERO;
      case (ev)
        EV_INC: if (known) opt_now = (opt_now < top) ? opt_now + 3'd1 : top;
        EV_DEC: if (known) opt_now = (opt_now > OPT_ZERO) ? opt_now - 3'd1 : OPT_ZERO;
        EV_ENTER: begin
          if (known) begin
            saved_opt[menu_now] = opt_now;
            committed = 1'b1;
          end
        end
        EV_ESC: begin
          menu_now = MENU_TUNE;
          opt_now = saved_opt[0];
        end
        EV_RIGHT: begin
          menu_now = (menu_now < MENU_LAST) ? menu_now + 3'd1 : MENU_FIRST;
          opt_now = saved_opt[menu_now];
        end
        EV_LEFT: begin
          if (menu_now > MENU_LAST) menu_now = MENU_LAST;
          menu_now = (menu_now > MENU_FIRST) ? menu_now - 3'd1 : MENU_LAST;
          opt_now = saved_opt[menu_now];
        end
        default: ;
      endcase
    end
    r.menu_state      = menu_now;
    r.selected_option = opt_now;
    r.frequency       = freq_now[FREQ_W-1:0];
    r.talk_active     = talk_now;
    r.update_flag     = committed;
    r.mode_setting    = saved_opt[1][1:0];
    r.agc_setting     = saved_opt[2][1:0];
    r.preamp_setting  = saved_opt[3];
    r.vox_setting     = saved_opt[4][1:0];
    r.band_setting    = saved_opt[5];
    return r;
  endfunction

  function automatic int field_diff(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  // Model upkeep and result checking, all on one edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      enc_b_up  = 1'b1;
      enc_both  = 1'b0;
      max_hz    = 32'(MAX_RESET);
      min_hz    = 32'(MIN_RESET);
      menu_now  = MENU_TUNE;
      opt_now   = OPTION_RESET;
      freq_now  = 32'(FREQ_RESET);
      saved_opt = SAVED_DEFAULT;
      talk_now  = 1'b0;
      committed = 1'b0;
    end else begin
      if (panel_ch.valid && panel_ch.ready) begin
        if (panel_due.size() == 0) begin
          $error("panel transfer with no state expected");
          mismatches++;
        end else begin
          want = panel_due.pop_front();
          mismatches += field_diff("menu_state", 32'(want.menu_state),
                                   32'(panel_ch.menu_state));
          mismatches += field_diff("selected_option", 32'(want.selected_option),
                                   32'(panel_ch.selected_option));
          mismatches += field_diff("frequency", 32'(want.frequency),
                                   32'(panel_ch.frequency));
          mismatches += field_diff("talk_active", 32'(want.talk_active),
                                   32'(panel_ch.talk_active));
          mismatches += field_diff("update_flag", 32'(want.update_flag),
                                   32'(panel_ch.update_flag));
          mismatches += field_diff("mode_setting", 32'(want.mode_setting),
                                   32'(panel_ch.mode_setting));
          mismatches += field_diff("agc_setting", 32'(want.agc_setting),
                                   32'(panel_ch.agc_setting));
          mismatches += field_diff("preamp_setting", 32'(want.preamp_setting),
                                   32'(panel_ch.preamp_setting));
          mismatches += field_diff("vox_setting", 32'(want.vox_setting),
                                   32'(panel_ch.vox_setting));
          mismatches += field_diff("band_setting", 32'(want.band_setting),
                                   32'(panel_ch.band_setting));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_B_HIGH_UP:  enc_b_up = cfg_ch.data[0];
          CFG_BOTH_EDGES: enc_both = cfg_ch.data[0];
          CFG_MAX_FREQ:   max_hz = 32'(cfg_ch.data);
          CFG_MIN_FREQ:   min_hz = 32'(cfg_ch.data);
          default: ;
        endcase
      end
      if (pin_ch.valid && pin_ch.ready) begin
        want = advance_panel(pin_ch.pin_number, pin_ch.edge_fall, pin_ch.edge_rise,
                             pin_ch.encoder_b_level);
        panel_due.push_back(row_typed ? row_want : want);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned stall;
    int unsigned served;
    panel_ch.ready <= 1'b0;
    stall = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served++;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        panel_ch.ready <= 1'b0;
        stall--;
      end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
        panel_ch.ready <= 1'b0;
        stall = pick_gap();
      end else begin
        panel_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one pin event and wait for its transfer; valid stays high afterwards
  task automatic offer_event(logic [PIN_W-1:0] pin, logic fall, logic rise, logic b_lvl,
                             logic typed, result_t want);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      pin_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_ch.valid           <= 1'b1;
    pin_ch.pin_number      <= pin;
    pin_ch.edge_fall       <= fall;
    pin_ch.edge_rise       <= rise;
    pin_ch.encoder_b_level <= b_lvl;
    row_typed              <= typed;
    row_want               <= want;
    do @(posedge clk); while (!pin_ch.ready);
  endtask

  // Mostly encoder turns and button presses, some PTT and some noise
  task automatic run_random(int unsigned n);
    int unsigned      sent;
    int unsigned      k;
    logic [PIN_W-1:0] pin;
    logic             fall;
    logic             rise;
    logic             b_lvl;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      b_lvl = 1'($urandom_range(0, 1));
      fall = 1'b1;
      rise = ($urandom_range(0, 4) == 0);
      if (k < 40) begin
        pin = PIN_ENC_A;
        if ($urandom_range(0, 3) == 0) begin
          fall = 1'b0;
          rise = 1'b1;
        end
      end else if (k < 70) begin
        k = $urandom_range(0, 99);
        pin = (k < 10) ? PIN_ESCAPE : (k < 30) ? PIN_ENTER : (k < 65) ? PIN_LEFT : PIN_RIGHT;
        if ($urandom_range(0, 9) == 0) fall = 1'b0;
      end else if (k < 80) begin
        pin = PIN_PTT;
        fall = 1'($urandom_range(0, 1));
        rise = !fall || ($urandom_range(0, 3) == 0);
      end else begin
        pin = PIN_W'($urandom_range(0, 31));
        fall = 1'($urandom_range(0, 1));
        rise = 1'($urandom_range(0, 1));
      end
      sent++;
      offer_event(pin, fall, rise, b_lvl, 1'b0, NOT_TYPED);
    end
  endtask

  // Sender goes quiet until every expected state has been seen
  task automatic wait_drained();
    pin_ch.valid <= 1'b0;
    do @(posedge clk); while (panel_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(logic b_up, logic both, logic [FREQ_W-1:0] max_f,
                            logic [FREQ_W-1:0] min_f);
    wait_drained();
    write_reg(CFG_B_HIGH_UP, FREQ_W'(b_up));
    write_reg(CFG_BOTH_EDGES, FREQ_W'(both));
    write_reg(CFG_MAX_FREQ, max_f);
    write_reg(CFG_MIN_FREQ, min_f);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned k;
    rst                    <= 1'b1;
    pin_ch.valid           <= 1'b0;
    pin_ch.pin_number      <= '0;
    pin_ch.edge_fall       <= 1'b0;
    pin_ch.edge_rise       <= 1'b0;
    pin_ch.encoder_b_level <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= '0;
    cfg_ch.data            <= '0;
    row_typed              <= 1'b0;
    row_want               <= NOT_TYPED;
    rx_calm                <= 1'b0;
    hold_asked             <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < SCRIPT_LEN; k++)
      offer_event(SCRIPT[k].pin, SCRIPT[k].fall, SCRIPT[k].rise, SCRIPT[k].b_lvl,
                  SCRIPT[k].typed, SCRIPT[k].want);

    // Reversed sense, both edges stepping, default window
    set_config(1'b0, 1'b1, MAX_RESET, MIN_RESET);
    run_random(330);

    // Widest window; result side holds off while events keep coming
    set_config(1'b1, 1'b1, FREQ_TOP, '0);
    hold_asked <= hold_asked + 1;
    tx_calm = 1'b1;
    run_random(60);
    tx_calm = 1'b0;
    wait_drained();
    run_random(270);

    // Empty window: every tuning step refused
    set_config(1'b0, 1'b0, '0, FREQ_TOP);
    run_random(150);

    // Window around the usual band, with a stretch of back-to-back transfers
    set_config(1'b1, 1'b0, FREQ_W'($urandom_range(5000000, 33554431)),
               FREQ_W'($urandom_range(0, 5000000)));
    tx_calm = 1'b1;
    rx_calm <= 1'b1;
    run_random(100);
    tx_calm = 1'b0;
    rx_calm <= 1'b0;
    run_random(250);

    // Anything goes
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               FREQ_W'($urandom_range(0, 33554431)), FREQ_W'($urandom_range(0, 33554431)));
    run_random(350);

    // Back to the defaults
    set_config(1'b1, 1'b0, MAX_RESET, MIN_RESET);
    run_random(330);

    pin_ch.valid <= 1'b0;
    k = 0;
    while (panel_due.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    if (panel_due.size() != 0) $error("%0d panel states never arrived", panel_due.size());
    if (mismatches == 0 && panel_due.size() == 0) begin
      $display("radio_panel_menu_tuner_tb passed");
    end else begin
      $display("radio_panel_menu_tuner_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("radio_panel_menu_tuner_tb failed");
    $finish;
  end

endmodule
